>>> sv/dpm_pkg.sv
// shared types, constants and helpers of the drive protection mode fsm
// no dependencies; imported by the top level and its checker

package dpm_pkg;

   // operating modes as reported on the result channel
   typedef enum logic [1:0] {
      MODE_STOP = 2'd0,
      MODE_INIT = 2'd1,
      MODE_RUN  = 2'd2,
      MODE_ERR  = 2'd3
   } mode_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_OVERCURRENT = 2'd0,
      CSR_OVERVOLTAGE = 2'd1,
      CSR_OVERSPEED   = 2'd2,
      CSR_AXIS_SELECT = 2'd3
   } csr_index_type;

   localparam int unsigned ValueWidth = 16;
   localparam int unsigned ReqDataWidth = 184;   // 177 payload bits, byte padded
   localparam int unsigned RspDataWidth = 32;    // 27 payload bits, byte padded
   localparam int unsigned ErrWidth = 7;

   localparam logic [ValueWidth-1:0] LimitReset = 16'h8000;

   // switch word bits
   localparam int unsigned SwHwX  = 0;
   localparam int unsigned SwThX  = 1;
   localparam int unsigned SwHwY  = 4;
   localparam int unsigned SwThY  = 5;
   localparam int unsigned SwInit = 8;
   localparam int unsigned SwRun  = 9;
   localparam int unsigned SwOil  = 11;

   // relay word codes
   localparam logic [15:0] RelayReset = 16'h0001;
   localparam logic [15:0] RelayOil   = 16'h0002;

   // error flag codes
   localparam logic [ErrWidth-1:0] ErrFirm = 7'h01;
   localparam logic [ErrWidth-1:0] ErrOvc  = 7'h02;
   localparam logic [ErrWidth-1:0] ErrOvv  = 7'h04;
   localparam logic [ErrWidth-1:0] ErrOvs  = 7'h08;
   localparam logic [ErrWidth-1:0] ErrHw   = 7'h10;

   // exact magnitude of a signed q15 value, -32768 gives 32768
   function automatic logic [ValueWidth:0] mag16(input logic signed [ValueWidth-1:0] v);
      logic [ValueWidth:0] ext;
      ext = {v[ValueWidth-1], v};
      return v[ValueWidth-1] ? (~ext + 17'd1) : ext;
   endfunction

   // strict compare of a magnitude against an unsigned limit
   function automatic logic over_limit(input logic signed [ValueWidth-1:0] v,
                                       input logic [ValueWidth-1:0] limit);
      return mag16(v) > {1'b0, limit};
   endfunction

endpackage

>>> sv/drive_protection_mode_fsm_unit.sv
// top level of the drive protection mode fsm: input stage, mode logic, result stage
// depends on dpm_pkg
//
// a transfer on req passes the input stage and then the result stage on its way to rsp
// throughput: one item per clock unless rsp stalls; the input stage and the result stage
//    form a two deep buffer, so one item is still taken while a finished result waits on rsp
// the mode, error latch, relay word and pwm state advance as an item leaves the input stage
// reset (synchronous, active high): mode stop, errors and relay word clear, pwm off,
//    first-tick flag set, all limits 32768, axis x, both stages empty

module drive_protection_mode_fsm_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata from bit 0: switch_word[15:0], firmware_fault, x_phase_u_current,
   // x_phase_w_current, x_dc_current, x_dc_voltage, x_speed, y_phase_u_current,
   // y_phase_w_current, y_dc_current, y_dc_voltage, y_speed (16 each), 7 zero bits
   input  logic [dpm_pkg::ReqDataWidth-1:0]    req_tdata,
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata from bit 0: mode[1:0], relay_word[15:0], pwm_enabled, controller_reset,
   // error_flags[6:0], 5 zero bits
   output logic [dpm_pkg::RspDataWidth-1:0]    rsp_tdata,
   // configuration write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [1:0]                          csr_index,
   input  logic [dpm_pkg::ValueWidth-1:0]      csr_data
);
   import dpm_pkg::*;

   // configuration registers
   logic [ValueWidth-1:0] ovc_limit_ff, ovv_limit_ff, ovs_limit_ff;
   logic                  axis_sel_ff;

   // input stage
   logic                    in_valid_ff, in_valid_in;
   logic [ReqDataWidth-1:0] in_data_ff;

   // block state
   mode_type                mode_ff, mode_in;
   logic [ErrWidth-1:0]     err_ff, err_in;
   logic [15:0]             relay_ff, relay_in;
   logic                    pwm_ff, pwm_in;
   logic                    first_ff;

   // result stage
   logic                    out_valid_ff, out_valid_in;
   logic [RspDataWidth-1:0] out_data_ff;

   logic advance;   // result stage can take a new item
   logic step;      // input stage item moves into the result stage

   // fields of the item in the input stage
   logic [15:0]              sw;
   logic                     fw_fault;
   logic signed [ValueWidth-1:0] sel_u, sel_w, sel_dci, sel_dcv, sel_spd;
   logic                     ini, run;

   // state as seen after the first-tick rule
   mode_type                mode_eff;
   logic [ErrWidth-1:0]     err_eff;
   logic                    pwm_eff;
   logic [ErrWidth-1:0]     err_chk;   // latched plus freshly detected faults
   logic                    pulse;

   assign csr_ready = 1'b1;

   // configuration writes, taken at any time
   always_ff @(posedge clock) begin
      if (reset) begin
         ovc_limit_ff <= LimitReset;
         ovv_limit_ff <= LimitReset;
         ovs_limit_ff <= LimitReset;
         axis_sel_ff  <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_OVERCURRENT: ovc_limit_ff <= csr_data;
            CSR_OVERVOLTAGE: ovv_limit_ff <= csr_data;
            CSR_OVERSPEED:   ovs_limit_ff <= csr_data;
            CSR_AXIS_SELECT: axis_sel_ff  <= csr_data[0];
            default:         ;
         endcase
      end
   end

   // handshake: the input stage frees up whenever its item moves on
   assign advance      = !out_valid_ff || rsp_tready;
   assign step         = in_valid_ff && advance;
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = step || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
      end
      if (step) begin
         out_data_ff <= {5'd0, err_in, pulse, pwm_in, relay_in, mode_in};
      end
   end

   // field unpacking; axis select picks the measurement set
   assign sw       = in_data_ff[15:0];
   assign fw_fault = in_data_ff[16];
   assign ini      = sw[SwInit];
   assign run      = sw[SwRun];

   always_comb begin
      if (axis_sel_ff) begin
         sel_u   = in_data_ff[112:97];
         sel_w   = in_data_ff[128:113];
         sel_dci = in_data_ff[144:129];
         sel_dcv = in_data_ff[160:145];
         sel_spd = in_data_ff[176:161];
      end else begin
         sel_u   = in_data_ff[32:17];
         sel_w   = in_data_ff[48:33];
         sel_dci = in_data_ff[64:49];
         sel_dcv = in_data_ff[80:65];
         sel_spd = in_data_ff[96:81];
      end
   end

   // first tick after reset: start from stop with pwm off, a switch already on is an error
   always_comb begin
      mode_eff = mode_ff;
      err_eff  = err_ff;
      pwm_eff  = pwm_ff;
      if (first_ff) begin
         mode_eff = MODE_STOP;
         pwm_eff  = 1'b0;
         if (ini || run) begin
            err_eff  = err_ff | ErrFirm;
            mode_eff = MODE_ERR;
         end
      end
   end

   // fault detection on the selected axis
   always_comb begin
      logic hw_fault;
      hw_fault = axis_sel_ff ? (sw[SwHwY] || sw[SwThY]) : (sw[SwHwX] || sw[SwThX]);
      err_chk  = err_eff;
      if (fw_fault) err_chk = err_chk | ErrFirm;
      if (over_limit(sel_u, ovc_limit_ff) || over_limit(sel_w, ovc_limit_ff) ||
          over_limit(sel_dci, ovc_limit_ff)) begin
         err_chk = err_chk | ErrOvc;
      end
      if (over_limit(sel_dcv, ovv_limit_ff)) err_chk = err_chk | ErrOvv;
      if (over_limit(sel_spd, ovs_limit_ff)) err_chk = err_chk | ErrOvs;
      if (hw_fault) err_chk = err_chk | ErrHw;
   end

   // next mode; later rules override earlier ones
   always_comb begin
      mode_in = mode_eff;
      case (mode_eff)
         MODE_STOP: begin
            if (ini) mode_in = run ? MODE_ERR : MODE_INIT;
         end
         MODE_INIT: begin
            if (err_chk != '0) mode_in = MODE_ERR;
            if (!ini)          mode_in = MODE_STOP;
            if (run)           mode_in = MODE_RUN;
         end
         MODE_RUN: begin
            if (err_chk != '0) mode_in = MODE_ERR;
            if (!run)          mode_in = MODE_INIT;
         end
         MODE_ERR: begin
            if (!run && !ini) mode_in = MODE_STOP;
         end
         default: mode_in = MODE_STOP;
      endcase
   end

   // outputs and latched state of this tick
   always_comb begin
      err_in   = err_eff;
      relay_in = relay_ff;
      pwm_in   = pwm_eff;
      pulse    = 1'b0;
      case (mode_eff)
         MODE_STOP: begin
            if (ini) begin
               relay_in = '0;
               pwm_in   = 1'b1;
               if (run) err_in = err_eff | ErrFirm;
            end
         end
         MODE_INIT: begin
            err_in   = err_chk;
            relay_in = '0;
            if (err_chk != '0) pwm_in = 1'b0;
            if (!ini) begin
               pulse  = 1'b1;
               pwm_in = 1'b0;
            end
         end
         MODE_RUN: begin
            err_in   = err_chk;
            relay_in = sw[SwOil] ? RelayOil : '0;
            if (err_chk != '0) pwm_in = 1'b0;
         end
         MODE_ERR: begin
            // error leds show the latch; clear when both switches are off
            relay_in = {1'b0, err_eff, 8'd0};
            if (!run && !ini) begin
               pulse    = 1'b1;
               err_in   = '0;
               relay_in = RelayReset;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_STOP;
         err_ff   <= '0;
         relay_ff <= '0;
         pwm_ff   <= 1'b0;
         first_ff <= 1'b1;
      end else if (step) begin
         mode_ff  <= mode_in;
         err_ff   <= err_in;
         relay_ff <= relay_in;
         pwm_ff   <= pwm_in;
         first_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

>>> sv/dpm_checker.sv
// port-level checks of the drive protection mode fsm, bound to the top level
// depends on dpm_pkg and drive_protection_mode_fsm_unit

module dpm_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [dpm_pkg::RspDataWidth-1:0] rsp_tdata
);
   import dpm_pkg::*;

   logic [1:0] rsp_mode;
   assign rsp_mode = rsp_tdata[1:0];

   // a stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // nothing comes out the cycle after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // the controller reset pulse only leaves init or error, landing in stop or run
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[19] |->
         rsp_mode == MODE_STOP || rsp_mode == MODE_RUN)
      else $error("controller reset in wrong mode");

   // in error mode the relay word has no reset relay and nothing in bits 2 to 7;
   // the oil bit may still be set when run mode falls into error
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_mode == MODE_ERR |-> !rsp_tdata[2] && rsp_tdata[9:4] == 6'd0)
      else $error("relay bits set in error mode");

   // request side is open whenever the result side is empty
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request side stuck with empty result side");

endmodule

bind drive_protection_mode_fsm_unit dpm_checker u_dpm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> bench/tb_drive_protection_mode_fsm_unit.sv
// self-checking bench for drive_protection_mode_fsm_unit: directed mode and fault
// sequences, a back-pressure run and random operator traffic, all checked per transfer
// depends on dpm_pkg and the top level of the block
`timescale 1ns / 100ps

module tb_drive_protection_mode_fsm_unit;
   import dpm_pkg::*;

   // one axis worth of measurements, lowest field last so it packs into the low bits
   typedef struct packed {
      logic signed [15:0] speed;
      logic signed [15:0] dc_voltage;
      logic signed [15:0] dc_current;
      logic signed [15:0] phase_w;
      logic signed [15:0] phase_u;
   } axis_meas_type;

   // one control tick as it sits in req_tdata (switch word at bit 0)
   typedef struct packed {
      axis_meas_type y;
      axis_meas_type x;
      logic          fw_fault;
      logic [15:0]   switches;
   } tick_type;

   // one result as it sits in rsp_tdata (mode at bit 0)
   typedef struct packed {
      logic [ErrWidth-1:0] errors;
      logic                ctrl_reset;
      logic                pwm;
      logic [15:0]         relay;
      mode_type            mode;
   } result_type;

   localparam logic [15:0] InitOn = 16'd1 << SwInit;
   localparam logic [15:0] RunOn  = 16'd1 << SwRun;
   localparam logic [15:0] OilOn  = 16'd1 << SwOil;
   localparam int unsigned MaxGap = 11;
   localparam int unsigned HoldCycles = 90;
   localparam int unsigned SettleCycles = 4;   // a little over the latency of the input and result stages

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [1:0]              csr_index = '0;
   logic [ValueWidth-1:0]   csr_data = '0;

   drive_protection_mode_fsm_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // predictor state: own copy of the mode machine and of the limit registers
   // ---------------------------------------------------------------------------------
   mode_type            st_mode = MODE_STOP;
   logic [ErrWidth-1:0] st_errors = '0;
   logic [15:0]         st_relay = '0;
   logic                st_pwm = 1'b0;
   logic                st_first = 1'b1;
   logic [15:0]         cfg_current_limit = LimitReset;
   logic [15:0]         cfg_voltage_limit = LimitReset;
   logic [15:0]         cfg_speed_limit = LimitReset;
   logic                cfg_axis = 1'b0;

   result_type  pending_results[$];   // expected results, oldest first
   int unsigned fail_count = 0;
   bit          idle_on = 1'b1;       // both sides insert random gaps when set
   int unsigned hold_request = 0;     // receiver hold-off asked for by a test
   int unsigned op_phase = 0;         // random operator: 0 off, 1 init, 2 init and run

   // exact 17-bit magnitude, so the most negative value gives 32768
   function automatic logic [16:0] q15_magnitude(input logic signed [15:0] v);
      logic signed [16:0] w;
      w = v;
      return (w < 0) ? 17'(-w) : 17'(w);
   endfunction

   function automatic logic above(input logic signed [15:0] v, input logic [15:0] limit);
      return q15_magnitude(v) > {1'b0, limit};
   endfunction

   // faults seen on the selected axis this tick
   function automatic logic [ErrWidth-1:0] tick_faults(input tick_type t);
      axis_meas_type       m;
      logic                hw;
      logic [ErrWidth-1:0] f;
      m  = cfg_axis ? t.y : t.x;
      hw = cfg_axis ? (t.switches[SwHwY] | t.switches[SwThY])
                    : (t.switches[SwHwX] | t.switches[SwThX]);
      f  = '0;
      if (t.fw_fault) f |= ErrFirm;
      if (above(m.phase_u, cfg_current_limit) || above(m.phase_w, cfg_current_limit) ||
          above(m.dc_current, cfg_current_limit)) f |= ErrOvc;
      if (above(m.dc_voltage, cfg_voltage_limit)) f |= ErrOvv;
      if (above(m.speed, cfg_speed_limit)) f |= ErrOvs;
      if (hw) f |= ErrHw;
      return f;
   endfunction

   // advance the mode machine by one tick and return what the block must report
   function automatic result_type advance_protection(input tick_type t);
      result_type r;
      logic       ini;
      logic       run;
      logic       pulse;
      ini   = t.switches[SwInit];
      run   = t.switches[SwRun];
      pulse = 1'b0;
      // first tick after reset: stop with pwm off, a switch already on is an error
      if (st_first) begin
         st_first = 1'b0;
         st_pwm   = 1'b0;
         st_mode  = MODE_STOP;
         if (ini || run) begin
            st_errors |= ErrFirm;
            st_mode = MODE_ERR;
         end
      end
      case (st_mode)
         MODE_STOP: begin
            if (ini) begin
               st_relay = '0;
               st_pwm   = 1'b1;
               st_mode  = MODE_INIT;
               // init and run together from stop is refused, pwm stays as started
               if (run) begin
                  st_errors |= ErrFirm;
                  st_mode = MODE_ERR;
               end
            end
         end
         MODE_INIT: begin
            st_errors |= tick_faults(t);
            st_relay = '0;
            // later rules win: error, then init off, then run on
            if (st_errors != '0) begin
               st_pwm  = 1'b0;
               st_mode = MODE_ERR;
            end
            if (!ini) begin
               pulse   = 1'b1;
               st_pwm  = 1'b0;
               st_mode = MODE_STOP;
            end
            if (run) st_mode = MODE_RUN;
         end
         MODE_RUN: begin
            st_errors |= tick_faults(t);
            st_relay = '0;
            if (st_errors != '0) begin
               st_pwm  = 1'b0;
               st_mode = MODE_ERR;
            end
            st_relay = t.switches[SwOil] ? RelayOil : 16'h0000;
            // run switch off falls back to init even over an error
            if (!run) st_mode = MODE_INIT;
         end
         default: begin
            st_relay = {1'b0, st_errors, 8'h00};
            // both switches off clears the latch and leaves only the reset relay on
            if (!run && !ini) begin
               pulse     = 1'b1;
               st_errors = '0;
               st_mode   = MODE_STOP;
               st_relay  = RelayReset;
            end
         end
      endcase
      r.mode       = st_mode;
      r.relay      = st_relay;
      r.pwm        = st_pwm;
      r.ctrl_reset = pulse;
      r.errors     = st_errors;
      return r;
   endfunction

   // ---------------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------------
   function automatic int unsigned pick_gap();
      if (!idle_on || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, MaxGap);
   endfunction

   function automatic tick_type quiet_tick(input logic [15:0] sw);
      tick_type t;
      t = '0;
      t.switches = sw;
      return t;
   endfunction

   // mostly small readings, now and then a full-range or extreme one
   function automatic logic signed [15:0] random_sample();
      logic signed [15:0] v;
      case ($urandom_range(0, 19))
         0: v = 16'($urandom);
         1: v = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
         default: begin
            v = 16'($urandom_range(0, 1500));
            if ($urandom_range(0, 1)) v = -v;
         end
      endcase
      return v;
   endfunction

   function automatic axis_meas_type random_axis();
      axis_meas_type m;
      m.phase_u    = random_sample();
      m.phase_w    = random_sample();
      m.dc_current = random_sample();
      m.dc_voltage = random_sample();
      m.speed      = random_sample();
      return m;
   endfunction

   // random operator walking off / init / run, with some raw noise mixed in
   function automatic tick_type random_tick();
      tick_type t;
      t.switches = 16'($urandom);
      t.x        = random_axis();
      t.y        = random_axis();
      if ($urandom_range(0, 99) < 15) begin
         t.fw_fault = 1'($urandom);
      end else begin
         t.fw_fault = ($urandom_range(0, 39) == 0);
         case ($urandom_range(0, 9))
            0: if (op_phase > 0) op_phase--;
            1, 2: if (op_phase < 2) op_phase++;
            default: ;
         endcase
         t.switches[SwInit] = (op_phase != 0);
         t.switches[SwRun]  = (op_phase == 2);
         // fault inputs mostly quiet so the run mode is reached and held
         if ($urandom_range(0, 19) != 0) begin
            t.switches[SwHwX] = 1'b0;
            t.switches[SwThX] = 1'b0;
            t.switches[SwHwY] = 1'b0;
            t.switches[SwThY] = 1'b0;
         end
      end
      return t;
   endfunction

   // offer one tick and predict it on the transfer; valid stays high for a back-to-back
   // tick and only drops when a gap is drawn
   task automatic offer_tick(input tick_type t);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {{(ReqDataWidth - $bits(tick_type)){1'b0}}, t};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(advance_protection(t));
   endtask

   // sender pauses until every expected result is back, then lets the block settle
   task automatic wait_results_done();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // one register transfer; valid is left high so writes can follow back to back
   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_OVERCURRENT: cfg_current_limit = value;
         CSR_OVERVOLTAGE: cfg_voltage_limit = value;
         CSR_OVERSPEED:   cfg_speed_limit = value;
         CSR_AXIS_SELECT: cfg_axis = value[0];
         default: ;
      endcase
   endtask

   task automatic program_limits(input logic [15:0] current, input logic [15:0] voltage,
                                 input logic [15:0] speed, input logic axis);
      write_reg(CSR_OVERCURRENT, current);
      write_reg(CSR_OVERVOLTAGE, voltage);
      write_reg(CSR_OVERSPEED, speed);
      write_reg(CSR_AXIS_SELECT, {15'd0, axis});
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] random_limit();
      case ($urandom_range(0, 7))
         0, 1: return LimitReset;
         2:    return 16'h0000;
         default: return 16'($urandom_range(2000, 32767));
      endcase
   endfunction

   // ---------------------------------------------------------------------------------
   // receiver: random ready, long hold-off on request, per-field check of each transfer
   // ---------------------------------------------------------------------------------
   int unsigned rsp_gap = 0;
   int unsigned hold_left = 0;
   logic        rsp_ready_next;
   result_type  rsp_got;
   result_type  rsp_want;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_got = result_type'(rsp_tdata[$bits(result_type)-1:0]);
         if (pending_results.size() == 0) begin
            $error("result transfer with no tick pending");
            fail_count++;
         end else begin
            rsp_want = pending_results.pop_front();
            if (rsp_got.mode !== rsp_want.mode) begin
               $error("mode: expected %0d, got %0d", rsp_want.mode, rsp_got.mode);
               fail_count++;
            end
            if (rsp_got.relay !== rsp_want.relay) begin
               $error("relay_word: expected %h, got %h", rsp_want.relay, rsp_got.relay);
               fail_count++;
            end
            if (rsp_got.pwm !== rsp_want.pwm) begin
               $error("pwm_enabled: expected %b, got %b", rsp_want.pwm, rsp_got.pwm);
               fail_count++;
            end
            if (rsp_got.ctrl_reset !== rsp_want.ctrl_reset) begin
               $error("controller_reset: expected %b, got %b",
                      rsp_want.ctrl_reset, rsp_got.ctrl_reset);
               fail_count++;
            end
            if (rsp_got.errors !== rsp_want.errors) begin
               $error("error_flags: expected %h, got %h", rsp_want.errors, rsp_got.errors);
               fail_count++;
            end
         end
         rsp_gap = pick_gap();
      end
      // a requested hold-off is counted here, independent of the sender
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready_next = 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ready_next = 1'b0;
      end else begin
         rsp_ready_next = 1'b1;
      end
      rsp_tready <= rsp_ready_next;
   end

   // ---------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------

   // first tick, the mode walk, pwm and oil relay, error display and clear
   task automatic test_modes();
      tick_type t;
      // first tick after reset with init already on goes straight to error
      offer_tick(quiet_tick(InitOn));
      // both switches off from error: clear, reset pulse, reset relay
      offer_tick(quiet_tick(16'h0000));
      // init and run together from stop is refused
      offer_tick(quiet_tick(InitOn | RunOn));
      offer_tick(quiet_tick(16'h0000));
      // stop to init starts pwm
      offer_tick(quiet_tick(InitOn));
      // most negative readings do not trip a limit of 32768
      t = quiet_tick(InitOn | RunOn);
      t.x = {5{16'h8000}};
      t.y = {5{16'h8000}};
      offer_tick(t);
      // oil pump relay follows its switch in run
      offer_tick(quiet_tick(InitOn | RunOn | OilOn));
      offer_tick(quiet_tick(InitOn | RunOn));
      // firmware fault in run with run off: back to init although the error latched
      t = quiet_tick(InitOn);
      t.fw_fault = 1'b1;
      offer_tick(t);
      // latched error in init selects error, error then shows the leds
      offer_tick(quiet_tick(InitOn));
      offer_tick(quiet_tick(InitOn));
      offer_tick(quiet_tick(16'h0000));
      wait_results_done();
   endtask

   // y axis selected, limits one below the extreme, later rules overriding earlier ones
   task automatic test_fault_sources();
      tick_type t;
      program_limits(16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
      offer_tick(quiet_tick(InitOn));
      // y thermal and y overspeed in init
      t = quiet_tick(InitOn | (16'd1 << SwThY));
      t.y.speed = 16'sh8000;
      offer_tick(t);
      offer_tick(quiet_tick(16'h0000));
      offer_tick(quiet_tick(InitOn));
      // y overcurrent, voltage equal to the limit does not trip, x faults are ignored;
      // init off overrides the error and pulses the reset
      t = quiet_tick(16'd1 << SwHwX);
      t.y.phase_w    = 16'sh8000;
      t.y.dc_voltage = 16'sh7fff;
      t.x.dc_current = 16'sh8000;
      offer_tick(t);
      // errors still latched: stop to init, then run on overrides the error selection
      offer_tick(quiet_tick(InitOn));
      offer_tick(quiet_tick(InitOn | RunOn));
      // latched error in run with run off drops to init, then init off to stop
      offer_tick(quiet_tick(16'h0000));
      offer_tick(quiet_tick(16'h0000));
      // clear the latch through error mode
      offer_tick(quiet_tick(InitOn));
      offer_tick(quiet_tick(InitOn));
      offer_tick(quiet_tick(16'h0000));
      wait_results_done();
   endtask

   // receiver holds off while ticks keep coming, so the block fills and stalls req
   task automatic test_backpressure();
      program_limits(LimitReset, LimitReset, LimitReset, 1'b0);
      idle_on = 1'b0;
      @(posedge clock);
      hold_request = HoldCycles;
      repeat (40) offer_tick(random_tick());
      wait_results_done();
      idle_on = 1'b1;
   endtask

   // random operator traffic over several limit settings, extremes first
   task automatic test_random_traffic();
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: program_limits(LimitReset, LimitReset, LimitReset, 1'b0);
            1: program_limits(16'h0000, 16'h0000, 16'h0000, 1'b1);
            default: program_limits(random_limit(), random_limit(), random_limit(),
                                    1'($urandom));
         endcase
         // one phase runs with no idling on either side
         idle_on = (phase != 3);
         repeat (315) offer_tick(random_tick());
         wait_results_done();
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_modes();
      test_fault_sources();
      test_backpressure();
      test_random_traffic();
      wait_results_done();
      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("tb_drive_protection_mode_fsm_unit passed");
      end else begin
         $display("tb_drive_protection_mode_fsm_unit failed");
      end
      $finish;
   end

   // hang guard, several times the slowest legal run
   initial begin
      #5_000_000;
      $display("tb_drive_protection_mode_fsm_unit failed");
      $finish;
   end

endmodule

>>> files.f
sv/dpm_pkg.sv
sv/drive_protection_mode_fsm_unit.sv
sv/dpm_checker.sv
bench/tb_drive_protection_mode_fsm_unit.sv
